>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BISL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define BISL_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/core/bisl_pkg.sv
package bisl_pkg;

   localparam int POS_BITS     = 24;
   localparam int MAX_DEPTH    = 64;
   localparam int DEPTH_BITS   = $clog2(MAX_DEPTH + 1);
   localparam int OUT_POS_BITS = 24;
   localparam int WIDE_BITS    = (POS_BITS > OUT_POS_BITS) ? POS_BITS : OUT_POS_BITS;
   localparam int ACC_BITS     = POS_BITS + 4;

   typedef logic [POS_BITS-1:0]     pos_type;
   typedef logic [DEPTH_BITS-1:0]   depth_type;
   typedef logic [OUT_POS_BITS-1:0] out_pos_type;
   typedef logic [ACC_BITS-1:0]     acc_type;

   localparam pos_type   POS_MAX     = '1;
   localparam depth_type DEPTH_LIMIT = DEPTH_BITS'(MAX_DEPTH);

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_O     = 8'h6f;

   // length of the key we look for
   localparam logic [2:0] KEY_LEN = 3'd4;

   typedef enum logic [3:0] {
      PH_START,
      PH_TOPKEY,
      PH_KEYLEN,
      PH_KEYBODY,
      PH_VALUE,
      PH_INT,
      PH_STRLEN,
      PH_STRBODY,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_NOKEY = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      out_pos_type span_start;
      out_pos_type span_end;
   } rsp_item_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [7:0] key_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0: ch = CH_I;
         2'd1: ch = CH_N;
         2'd2: ch = CH_F;
         default: ch = CH_O;
      endcase
      return ch;
   endfunction

   // offsets leave the block on a fixed 24-bit field
   function automatic out_pos_type out_pos(input pos_type p);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(p);
      return w[OUT_POS_BITS-1:0];
   endfunction

endpackage

>>> rtl/core/bisl_in_stage.sv
module bisl_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bisl_pkg::req_item_type req_item,
   input  logic                  down_ready,
   output logic                  fire,
   output bisl_pkg::req_item_type item
);
   import bisl_pkg::*;

   logic         hold_v_ff, hold_v_in;
   req_item_type item_ff, item_in;

   assign fire       = hold_v_ff && down_ready;
   assign req_tready = !hold_v_ff || fire;
   assign item       = item_ff;

   always_comb begin
      hold_v_in = hold_v_ff;
      item_in   = item_ff;
      if (req_tvalid && req_tready) begin
         hold_v_in = 1'b1;
         item_in   = req_item;
      end else if (fire) begin
         hold_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
      item_ff <= item_in;
   end

endmodule

>>> rtl/core/bisl_scan.sv
`include "assert_macros.svh"

module bisl_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  bisl_pkg::req_item_type item,
   output logic                   push,
   output bisl_pkg::rsp_item_type push_item
);
   import bisl_pkg::*;

   phase_type  phase_ff, phase_in;
   depth_type  depth_ff, depth_in;
   pos_type    acc_ff, acc_in;
   pos_type    left_ff, left_in;
   pos_type    pos_ff, pos_in;
   logic [2:0] kp_ff, kp_in;
   logic       kd_ff, kd_in;
   pos_type    vstart_ff, vstart_in;

   logic [7:0] c;
   pos_type    acc_base;
   acc_type    acc10;
   logic       dig_ok;
   pos_type    dig_val;
   logic       vdone;
   logic       report;
   logic       found;
   status_type st;

   assign c = item.data_byte;

   // a fresh length starts from zero where the first digit opens it
   assign acc_base = (phase_ff == PH_TOPKEY || phase_ff == PH_VALUE) ? '0 : acc_ff;
   assign acc10    = (ACC_BITS'(acc_base) << 3) + (ACC_BITS'(acc_base) << 1)
                   + ACC_BITS'(c[3:0]);
   assign dig_ok   = is_digit(c) && (acc10[ACC_BITS-1:POS_BITS] == '0);
   assign dig_val  = acc10[POS_BITS-1:0];

   always_comb begin
      phase_in  = phase_ff;
      depth_in  = depth_ff;
      acc_in    = acc_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      kp_in     = kp_ff;
      kd_in     = kd_ff;
      vstart_in = vstart_ff;
      vdone     = 1'b0;
      report    = 1'b0;
      found     = 1'b0;
      st        = ST_BAD;

      if (phase_ff != PH_DONE && pos_ff == POS_MAX) begin
         report = 1'b1;
      end else begin
         case (phase_ff)
            PH_START: begin
               if (c == CH_D) phase_in = PH_TOPKEY;
               else report = 1'b1;
            end
            PH_TOPKEY: begin
               if (c == CH_E) begin
                  report = 1'b1;
                  st     = ST_NOKEY;
               end else if (dig_ok) begin
                  acc_in   = dig_val;
                  phase_in = PH_KEYLEN;
               end else begin
                  report = 1'b1;
               end
            end
            PH_KEYLEN: begin
               if (c == CH_COLON) begin
                  left_in  = acc_ff;
                  kp_in    = '0;
                  kd_in    = (acc_ff != POS_BITS'(KEY_LEN));
                  depth_in = '0;
                  if (acc_ff == '0) begin
                     vstart_in = pos_ff + 1'b1;
                     phase_in  = PH_VALUE;
                  end else begin
                     phase_in = PH_KEYBODY;
                  end
               end else if (dig_ok) begin
                  acc_in = dig_val;
               end else begin
                  report = 1'b1;
               end
            end
            PH_KEYBODY: begin
               if (kp_ff < KEY_LEN) begin
                  if (c != key_char(kp_ff[1:0])) kd_in = 1'b1;
                  kp_in = kp_ff + 1'b1;
               end
               left_in = left_ff - 1'b1;
               if (left_ff == POS_BITS'(1)) begin
                  vstart_in = pos_ff + 1'b1;
                  phase_in  = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (c == CH_I) begin
                  phase_in = PH_INT;
               end else if (c == CH_L || c == CH_D) begin
                  if (depth_ff >= DEPTH_LIMIT) report = 1'b1;
                  else depth_in = depth_ff + 1'b1;
               end else if (is_digit(c)) begin
                  if (dig_ok) begin
                     acc_in   = dig_val;
                     phase_in = PH_STRLEN;
                  end else begin
                     report = 1'b1;
                  end
               end else if (c == CH_E && depth_ff != '0) begin
                  depth_in = depth_ff - 1'b1;
                  vdone    = 1'b1;
               end else begin
                  report = 1'b1;
               end
            end
            PH_INT: begin
               if (c == CH_E) vdone = 1'b1;
            end
            PH_STRLEN: begin
               if (c == CH_COLON) begin
                  left_in = acc_ff;
                  if (acc_ff == '0) vdone = 1'b1;
                  else phase_in = PH_STRBODY;
               end else if (dig_ok) begin
                  acc_in = dig_val;
               end else begin
                  report = 1'b1;
               end
            end
            PH_STRBODY: begin
               left_in = left_ff - 1'b1;
               if (left_ff == POS_BITS'(1)) vdone = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // a value closed: back into the container, or done with a top-level value
      if (vdone) begin
         if (depth_in != '0) begin
            phase_in = PH_VALUE;
         end else if (kp_ff == KEY_LEN && !kd_ff) begin
            report = 1'b1;
            found  = 1'b1;
            st     = ST_FOUND;
         end else begin
            phase_in = PH_TOPKEY;
         end
      end

      if (report) begin
         phase_in = PH_DONE;
      end else if (item.last && phase_in != PH_DONE) begin
         report = 1'b1;
         st     = ST_BAD;
      end

      if (phase_in != PH_DONE) pos_in = pos_ff + 1'b1;

      if (item.last) begin
         phase_in  = PH_START;
         depth_in  = '0;
         acc_in    = '0;
         left_in   = '0;
         pos_in    = '0;
         kp_in     = '0;
         kd_in     = 1'b0;
         vstart_in = '0;
      end
   end

   assign push                 = fire && report;
   assign push_item.status     = st;
   assign push_item.span_start = found ? out_pos(vstart_ff) : '0;
   assign push_item.span_end   = found ? out_pos(pos_ff + 1'b1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         depth_ff  <= '0;
         acc_ff    <= '0;
         left_ff   <= '0;
         pos_ff    <= '0;
         kp_ff     <= '0;
         kd_ff     <= 1'b0;
         vstart_ff <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         depth_ff  <= depth_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         kp_ff     <= kp_in;
         kd_ff     <= kd_in;
         vstart_ff <= vstart_in;
      end
   end

   `BISL_NEVER(a_depth_bound, clock, reset, depth_ff > DEPTH_LIMIT, "nest depth past limit")
   `BISL_NEVER(a_key_bound, clock, reset, kp_ff > KEY_LEN, "key progress past key length")
   `BISL_ASSERT(a_report_done, clock, reset, push && !item.last |=> phase_ff == PH_DONE, "no done after report")

endmodule

>>> rtl/core/bisl_out_skid.sv
`include "assert_macros.svh"

module bisl_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bisl_pkg::rsp_item_type push_item,
   output logic                   up_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output bisl_pkg::rsp_item_type rsp_item
);
   import bisl_pkg::*;

   logic         main_v_ff, main_v_in;
   logic         skid_v_ff, skid_v_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign pop        = main_v_ff && rsp_tready;
   assign up_ready   = !skid_v_ff;
   assign rsp_tvalid = main_v_ff;
   assign rsp_item   = main_ff;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         if (pop) begin
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!main_v_ff || pop) begin
            main_in   = push_item;
            main_v_in = 1'b1;
         end else begin
            skid_in   = push_item;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         main_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `BISL_ASSERT(a_skid_behind_main, clock, reset, skid_v_ff |-> main_v_ff, "skid full, main empty")
   `BISL_NEVER(a_push_into_full, clock, reset, push && skid_v_ff, "response pushed while full")

endmodule

>>> rtl/core/bencode_info_span_locator.sv
// Bencode "info" span locator.
// Scans a bencoded message one byte per request and reports where the value
// stored under key "info" in the top-level dictionary sits in the message.
// req channel: one message byte per request, tlast on the final byte.
// rsp channel: at most one response per message; tuser carries the status
//   (found, top dictionary closed without the key, malformed) and tdata the
//   start offset and the exclusive end offset (both zero unless found).
// After its response a message's remaining bytes are dropped up to tlast;
// tlast always rearms the scanner for the next message.
// Throughput: one byte per cycle while the output stage has room. Each
// byte passes an input register and a single step of the parse state, and
// a response is registered in the output stage from the step on that byte.
// The parse state update for one byte is the loop that sets that rate.
// Reset clears the parse state and both stages; no response is pending.
// A two-entry output stage absorbs a stalled receiver: bytes keep flowing
// until a second response waits, then req_tready drops until rsp_tready.
module bencode_info_span_locator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last byte of the message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] span_start, [47:24] span_end
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import bisl_pkg::*;

   req_item_type req_item;
   req_item_type item;
   rsp_item_type push_item;
   rsp_item_type rsp_item;
   logic         fire;
   logic         push;
   logic         up_ready;

   assign req_item.data_byte = req_tdata;
   assign req_item.last      = req_tlast;

   // input register
   bisl_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .down_ready (up_ready),
      .fire       (fire),
      .item       (item)
   );

   // parse state and per-byte step
   bisl_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item),
      .push      (push),
      .push_item (push_item)
   );

   // response register with skid entry
   bisl_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .up_ready   (up_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {rsp_item.span_end, rsp_item.span_start};
   assign rsp_tuser = rsp_item.status;

endmodule

>>> tb/tb_bencode_info_span_locator.sv
`timescale 1ns / 1ps

module tb_bencode_info_span_locator;
   import bisl_pkg::*;

   // Run sizing. The watchdog limit sits well above the receiver hold-off,
   // the longest quiet stretch a correct run can show.
   localparam int RANDOM_BYTES = 1650;
   localparam int HOLD_AFTER   = 30;     // responses taken before the long hold
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;     // covers the input register plus output stage

   localparam longint unsigned POS_LIMIT = (64'd1 << POS_BITS) - 1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] data_byte
   logic        req_tlast = 1'b0;     // last byte of the message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [23:0] span_start, [47:24] span_end
   logic [1:0]  rsp_tuser;            // [1:0] status

   bencode_info_span_locator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Span scoreboard. Carries its own copy of the parse state: each accepted
   // request byte advances it, and any report it yields is queued as the
   // expected response. Responses are matched in order.
   // ------------------------------------------------------------------------
   class span_scoreboard;
      phase_type         phase;
      int unsigned       nest;
      longint unsigned   len_acc;
      longint unsigned   remaining;
      longint unsigned   pos;
      int unsigned       key_idx;
      bit                key_mismatch;
      longint unsigned   val_start;

      status_type        rep_status;
      longint unsigned   rep_start;
      longint unsigned   rep_end;

      logic [7:0]        info_key[4] = '{CH_I, CH_N, CH_F, CH_O};
      rsp_item_type      expected_spans[$];
      int                faults;

      function new();
         rearm();
         faults = 0;
      endfunction

      function void rearm();
         phase        = PH_START;
         nest         = 0;
         len_acc      = 0;
         remaining    = 0;
         pos          = 0;
         key_idx      = 0;
         key_mismatch = 1'b0;
         val_start    = 0;
      endfunction

      function bit numeral(logic [7:0] c);
         return (c >= 8'h30) && (c <= 8'h39);
      endfunction

      // false when the length no longer fits in POS_BITS
      function bit accum_digit(logic [7:0] c);
         longint unsigned v;
         v = len_acc * 10 + longint'(c - 8'h30);
         if (v > POS_LIMIT)
            return 1'b0;
         len_acc = v;
         return 1'b1;
      endfunction

      // a value ended on byte 'at'; only a top-level "info" value reports
      function bit value_closed(longint unsigned at);
         if (nest > 0) begin
            phase = PH_VALUE;
            return 1'b0;
         end
         if (key_idx == 4 && !key_mismatch) begin
            rep_status = ST_FOUND;
            rep_start  = val_start;
            rep_end    = at + 1;
            phase      = PH_DONE;
            return 1'b1;
         end
         phase = PH_TOPKEY;
         return 1'b0;
      endfunction

      function void note_request(logic [7:0] c, logic is_last);
         longint unsigned at;
         bit              fired;
         rsp_item_type    item;
         at         = pos;
         fired      = 1'b0;
         rep_status = ST_BAD;
         rep_start  = 0;
         rep_end    = 0;
         if (phase != PH_DONE && at >= POS_LIMIT) begin
            fired = 1'b1;
         end else begin
            case (phase)
               PH_START: begin
                  if (c == CH_D) phase = PH_TOPKEY;
                  else fired = 1'b1;
               end
               PH_TOPKEY: begin
                  if (c == CH_E) begin
                     fired      = 1'b1;
                     rep_status = ST_NOKEY;
                  end else if (numeral(c)) begin
                     len_acc = 0;
                     if (accum_digit(c)) phase = PH_KEYLEN;
                     else fired = 1'b1;
                  end else begin
                     fired = 1'b1;
                  end
               end
               PH_KEYLEN: begin
                  if (c == CH_COLON) begin
                     remaining    = len_acc;
                     key_idx      = 0;
                     key_mismatch = (len_acc != 4);
                     nest         = 0;
                     if (remaining == 0) begin
                        val_start = at + 1;
                        phase     = PH_VALUE;
                     end else begin
                        phase = PH_KEYBODY;
                     end
                  end else if (!numeral(c) || !accum_digit(c)) begin
                     fired = 1'b1;
                  end
               end
               PH_KEYBODY: begin
                  if (key_idx < 4) begin
                     if (c != info_key[key_idx]) key_mismatch = 1'b1;
                     key_idx++;
                  end
                  remaining--;
                  if (remaining == 0) begin
                     val_start = at + 1;
                     phase     = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (c == CH_I) begin
                     phase = PH_INT;
                  end else if (c == CH_L || c == CH_D) begin
                     if (nest >= MAX_DEPTH) fired = 1'b1;
                     else nest++;
                  end else if (numeral(c)) begin
                     len_acc = 0;
                     if (accum_digit(c)) phase = PH_STRLEN;
                     else fired = 1'b1;
                  end else if (c == CH_E && nest > 0) begin
                     nest--;
                     fired = value_closed(at);
                  end else begin
                     fired = 1'b1;
                  end
               end
               PH_INT: begin
                  if (c == CH_E) fired = value_closed(at);
               end
               PH_STRLEN: begin
                  if (c == CH_COLON) begin
                     remaining = len_acc;
                     if (remaining == 0) fired = value_closed(at);
                     else phase = PH_STRBODY;
                  end else if (!numeral(c) || !accum_digit(c)) begin
                     fired = 1'b1;
                  end
               end
               PH_STRBODY: begin
                  remaining--;
                  if (remaining == 0) fired = value_closed(at);
               end
               default: ;
            endcase
         end

         // message ran out before any report: truncated
         if (fired) begin
            phase = PH_DONE;
         end else if (is_last && phase != PH_DONE) begin
            fired      = 1'b1;
            rep_status = ST_BAD;
         end
         if (phase != PH_DONE) pos = at + 1;
         if (is_last) rearm();

         if (fired) begin
            item.status     = rep_status;
            item.span_start = (rep_status == ST_FOUND) ? out_pos_type'(rep_start) : '0;
            item.span_end   = (rep_status == ST_FOUND) ? out_pos_type'(rep_end) : '0;
            expected_spans.insert(expected_spans.size(), item);
         end
      endfunction

      function void check_response(logic [1:0] status, logic [23:0] s, logic [23:0] e);
         rsp_item_type want;
         if (expected_spans.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: unexpected response status %0d start %0d end %0d",
                        $time, status, s, e);
            return;
         end
         want = expected_spans.pop_front();
         if (status !== want.status || s !== want.span_start || e !== want.span_end) begin
            faults++;
            if (faults <= 10)
               $display("%0t: span mismatch: expected status %0d [%0d,%0d) got %0d [%0d,%0d)",
                        $time, want.status, want.span_start, want.span_end, status, s, e);
         end
      endfunction

      function int pending();
         return expected_spans.size();
      endfunction
   endclass

   span_scoreboard spans = new();

   // ------------------------------------------------------------------------
   // Stimulus construction. Messages are assembled byte by byte in msg and
   // then moved to the request list with tlast on the final byte.
   // ------------------------------------------------------------------------
   logic [7:0]   msg[$];
   req_item_type stim[$];

   function automatic void put_byte(logic [7:0] b);
      msg.insert(msg.size(), b);
   endfunction

   function automatic void add_text(string t);
      int i;
      for (i = 0; i < t.len(); i++) put_byte(t[i]);
   endfunction

   // length prefix, sometimes with a leading zero (legal)
   function automatic void add_length(int unsigned n);
      if ($urandom_range(0, 5) == 0) put_byte(8'h30);
      add_text($sformatf("%0d", n));
      put_byte(CH_COLON);
   endfunction

   function automatic void add_random_bytes(int unsigned n);
      repeat (n) put_byte(8'($urandom));
   endfunction

   // one random value: integer, string, list or dictionary
   function automatic void add_value(int lvl);
      int unsigned kind;
      int unsigned n;
      logic [7:0]  b;
      kind = $urandom_range(0, (lvl >= 3) ? 1 : 3);
      case (kind)
         0: begin
            put_byte(CH_I);
            repeat ($urandom_range(0, 4)) begin
               b = 8'($urandom);
               if (b == CH_E) b = 8'h2d;
               put_byte(b);
            end
            put_byte(CH_E);
         end
         1: begin
            n = $urandom_range(0, 6);
            add_length(n);
            add_random_bytes(n);
         end
         2: begin
            put_byte(CH_L);
            repeat ($urandom_range(0, 3)) add_value(lvl + 1);
            put_byte(CH_E);
         end
         default: begin
            // nested dict: keys are just strings to the scanner
            put_byte(CH_D);
            repeat ($urandom_range(0, 3)) begin
               n = $urandom_range(0, 4);
               add_length(n);
               add_random_bytes(n);
               add_value(lvl + 1);
            end
            put_byte(CH_E);
         end
      endcase
   endfunction

   // top-level key, biased toward "info" and its near misses
   function automatic void add_top_key();
      int unsigned n;
      case ($urandom_range(0, 7))
         0, 1, 2: begin add_length(4); add_text("info"); end
         3:       begin add_length(3); add_text("inf"); end
         4:       begin add_length(5); add_text("infos"); end
         5:       begin
            add_length(4);
            add_text(($urandom_range(0, 1) != 0) ? "Info" : "infp");
         end
         6:       add_length(0);
         default: begin
            n = $urandom_range(1, 5);
            add_length(n);
            add_random_bytes(n);
         end
      endcase
   endfunction

   function automatic void add_clean_dict();
      put_byte(CH_D);
      repeat ($urandom_range(0, 4)) begin
         add_top_key();
         add_value(0);
      end
      put_byte(CH_E);
      // trailing bytes after the closing 'e' are dropped by the block
      if ($urandom_range(0, 3) == 0) add_random_bytes($urandom_range(1, 3));
   endfunction

   function automatic void close_message();
      int i;
      for (i = 0; i < msg.size(); i++)
         stim.insert(stim.size(), '{data_byte: msg[i], last: (i == msg.size() - 1)});
      msg.delete();
   endfunction

   function automatic void build_random_message();
      int unsigned pick;
      int unsigned k;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         add_clean_dict();
      end else if (pick < 75) begin
         // broken: one byte overwritten or the message cut short
         add_clean_dict();
         if ($urandom_range(0, 1) != 0) begin
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
         end else if (msg.size() > 1) begin
            k = $urandom_range(1, msg.size() - 1);
            while (msg.size() > k) void'(msg.pop_back());
         end
      end else if (pick < 79) begin
         // deep nesting under "info", around the depth limit
         put_byte(CH_D);
         add_text("4:info");
         k = $urandom_range(MAX_DEPTH - 2, MAX_DEPTH + 2);
         repeat (k) put_byte(($urandom_range(0, 1) != 0) ? CH_L : CH_D);
         repeat (k) put_byte(CH_E);
         put_byte(CH_E);
      end else if (pick < 83) begin
         // lengths at and just past the position width
         put_byte(CH_D);
         case ($urandom_range(0, 3))
            0: add_text("16777216");
            1: add_text("0016777215:ab");
            2: add_text("4:info99999999");
            default: add_text("4:info16777215:x");
         endcase
      end else begin
         add_random_bytes($urandom_range(1, 6));
      end
      close_message();
   endfunction

   // gap draw shared by both sides; occasional bursts with no gaps at all
   function automatic int next_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: one request per list entry, note it on the handshake.
   // Outputs are read right after the edge, before any NBA lands, so they
   // hold the values the block saw at that edge.
   // ------------------------------------------------------------------------
   task automatic drive_requests();
      int burst;
      int gap;
      burst = 0;
      foreach (stim[i]) begin
         gap = next_gap(burst);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stim[i].data_byte;
         req_tlast  <= stim[i].last;
         do @(posedge clock); while (!req_tready);
         spans.note_request(stim[i].data_byte, stim[i].last);
      end
      req_tvalid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: random backpressure, plus one long hold-off so the
   // output stage fills and req_tready has to drop while requests keep coming.
   // ------------------------------------------------------------------------
   initial begin
      int burst;
      int gap;
      int taken;
      burst = 0;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
         else gap = next_gap(burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         spans.check_response(rsp_tuser, rsp_tdata[23:0], rsp_tdata[47:24]);
         taken++;
      end
   end

   // watchdog: too long without any handshake on either side
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("bencode_info_span_locator verification failed");
            $finish;
         end
      end
   end

   initial begin
      int directed_count;

      // directed: byte 00 as a lone message (no opening 'd'), empty dict,
      // found span, byte FF where a key must start, truncated key,
      // key length one past the position range
      put_byte(8'h00);
      close_message();
      add_text("de");
      close_message();
      add_text("d4:infoi5ee");
      close_message();
      put_byte(CH_D);
      put_byte(8'hff);
      close_message();
      add_text("d1:");
      close_message();
      add_text("d16777216");
      close_message();
      directed_count = stim.size();

      while (stim.size() < directed_count + RANDOM_BYTES) build_random_message();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      drive_requests();

      while (spans.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (spans.faults == 0) begin
         $display("bencode_info_span_locator verification clean");
      end else begin
         $display("bencode_info_span_locator verification failed");
      end
      $finish;
   end

endmodule
